// File: sv/lgsm_pkg.sv
// Shared types, constants and register indexes of the light gate speed meter.
package lgsm_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DivNumW  = 18;
  localparam int unsigned DivDenW  = 16;
  localparam int unsigned DivCntW  = $clog2(DivNumW);

  localparam logic [CfgIdxW-1:0] RegLowLimit     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHighLimit    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGateDistance = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTicksPerMs   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTimeoutTicks = 3'd4;

  localparam logic [6:0]  LowLimitRst     = 7'd2;
  localparam logic [6:0]  HighLimitRst    = 7'd98;
  localparam logic [7:0]  GateDistanceRst = 8'd38;
  localparam logic [7:0]  TicksPerMsRst   = 8'd16;
  localparam logic [15:0] TimeoutTicksRst = 16'd62500;

  localparam logic [DivNumW-1:0] SpeedScale = 18'd1000;
  localparam logic [5:0]  ServoTop   = 6'd34;
  localparam logic [6:0]  SpeedCap   = 7'd99;
  localparam logic [15:0] U16Max     = 16'hFFFF;
  // Reciprocal of ten, exact for every 16-bit value after a shift by 19.
  localparam logic [15:0] RecipTen   = 16'd52429;
  // 23/99 scaled by 2^16, exact for whole speeds up to 99 after a shift by 16.
  localparam logic [13:0] ServoSlope = 14'd15226;

  localparam logic EvMeasure = 1'b0;
  localparam logic EvTimeout = 1'b1;

  localparam logic [1:0] ClassWithin = 2'd0;
  localparam logic [1:0] ClassAbove  = 2'd1;
  localparam logic [1:0] ClassBelow  = 2'd2;

  typedef struct packed {
    logic        event_res;
    logic [15:0] elapsed_ms;
    logic [15:0] speed_tenths;
    logic [1:0]  limit_class;
    logic [5:0]  servo_pulse;
  } res_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quo;
  } div_rsp_t;

endpackage

// File: sv/lgsm_if.sv
// Handshake channel interfaces for samples, results and register writes.
interface lgsm_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic start_clear;
  logic stop_clear;
  modport source (output valid, output kind, output start_clear, output stop_clear,
                  input ready);
  modport sink (input valid, input kind, input start_clear, input stop_clear,
                output ready);
endinterface

interface lgsm_out_if;
  logic        valid;
  logic        ready;
  logic        event_res;
  logic [15:0] elapsed_ms;
  logic [15:0] speed_tenths;
  logic [1:0]  limit_class;
  logic [5:0]  servo_pulse;
  modport source (output valid, output event_res, output elapsed_ms, output speed_tenths,
                  output limit_class, output servo_pulse, input ready);
  modport sink (input valid, input event_res, input elapsed_ms, input speed_tenths,
                input limit_class, input servo_pulse, output ready);
endinterface

interface lgsm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/light_gate_speed_meter.sv
// Light gate speed meter: a sample that completes a measurement holds off the next request
// until its result is loaded. The accepting cycle is followed by two passes of the shared
// bit-serial divider, first for milliseconds, then for speed. A state each then gives whole
// cm/s and the limit class, and one loads the result register. A time of zero milliseconds
// skips the second pass. Timer ticks and other samples leave the meter idle, and a timeout
// goes straight to the state that loads the result register. A result that waits for the
// output register holds the input off until it moves on.
module light_gate_speed_meter
  import lgsm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  lgsm_in_if.sink    in_i,
  lgsm_out_if.source out_o,
  lgsm_cfg_if.sink   cfg_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_MS,
    S_DIV_SPD,
    S_WHOLE,
    S_CLASS,
    S_EMIT
  } state_e;

  state_e state_q;

  logic [6:0]  low_q, high_q;
  logic [7:0]  gd_q, tpm_q;
  logic [15:0] tmo_q;

  logic        last_start_q, last_stop_q, armed_q;
  logic [15:0] tick_q;
  logic [15:0] ms_q, spd_q;
  logic [12:0] whole_q;
  res_t        pend_q, res_q;
  logic        out_valid_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        accept, arm, armed_eff, stop_hit, is_tick;
  logic [15:0] tick_inc;
  logic [7:0]  tpm_eff;
  logic [15:0] ms_quo;
  logic [31:0] whole_prod;
  logic [6:0]  whole_cap, high_eff;
  logic [20:0] servo_prod;

  assign accept    = in_i.valid && (state_q == S_IDLE);
  assign is_tick   = in_i.kind;
  assign arm       = !in_i.start_clear && last_start_q && !armed_q;
  assign armed_eff = armed_q || arm;
  assign stop_hit  = !in_i.stop_clear && last_stop_q && armed_eff;
  assign tick_inc  = (tick_q == U16Max) ? tick_q : tick_q + 16'd1;
  assign tpm_eff   = (tpm_q == 8'd0) ? 8'd1 : tpm_q;
  assign ms_quo    = div_rsp.quo[15:0];

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = {2'b00, (arm ? 16'd0 : tick_q)};
    div_req.den   = {8'd0, tpm_eff};
    if (state_q == S_DIV_MS) begin
      div_req.num   = DivNumW'(gd_q) * SpeedScale;
      div_req.den   = ms_quo;
      div_req.start = div_rsp.done && (ms_quo != 16'd0);
    end else begin
      div_req.start = accept && !is_tick && stop_hit;
    end
  end

  lgsm_div u_div (
    .clk_i,
    .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign whole_prod = spd_q * RecipTen;
  assign whole_cap  = (whole_q > 13'(SpeedCap)) ? SpeedCap : whole_q[6:0];
  assign high_eff   = (high_q < low_q) ? low_q : high_q;
  assign servo_prod = whole_cap * ServoSlope;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LowLimitRst;
      high_q <= HighLimitRst;
      gd_q   <= GateDistanceRst;
      tpm_q  <= TicksPerMsRst;
      tmo_q  <= TimeoutTicksRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegLowLimit:     low_q  <= cfg_i.data[6:0];
        RegHighLimit:    high_q <= cfg_i.data[6:0];
        RegGateDistance: gd_q   <= cfg_i.data[7:0];
        RegTicksPerMs:   tpm_q  <= cfg_i.data[7:0];
        RegTimeoutTicks: tmo_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      last_start_q <= 1'b1;
      last_stop_q  <= 1'b1;
      armed_q      <= 1'b0;
      tick_q       <= '0;
      out_valid_q  <= 1'b0;
      ms_q         <= '0;
      spd_q        <= '0;
      whole_q      <= '0;
      pend_q       <= '0;
      res_q        <= '0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (is_tick) begin
              if (armed_q) begin
                tick_q <= tick_inc;
                if (tick_inc >= tmo_q) begin
                  armed_q             <= 1'b0;
                  pend_q.event_res    <= EvTimeout;
                  pend_q.elapsed_ms   <= '0;
                  pend_q.speed_tenths <= '0;
                  pend_q.limit_class  <= ClassWithin;
                  pend_q.servo_pulse  <= ServoTop;
                  state_q             <= S_EMIT;
                end
              end
            end else begin
              if (arm) begin
                tick_q <= '0;
              end
              last_start_q <= in_i.start_clear;
              last_stop_q  <= in_i.stop_clear;
              if (stop_hit) begin
                armed_q <= 1'b0;
                state_q <= S_DIV_MS;
              end else begin
                armed_q <= armed_eff;
              end
            end
          end
        end
        S_DIV_MS: begin
          if (div_rsp.done) begin
            ms_q <= ms_quo;
            if (ms_quo == 16'd0) begin
              spd_q   <= U16Max;
              state_q <= S_WHOLE;
            end else begin
              state_q <= S_DIV_SPD;
            end
          end
        end
        S_DIV_SPD: begin
          if (div_rsp.done) begin
            spd_q   <= (div_rsp.quo[DivNumW-1:16] != '0) ? U16Max : div_rsp.quo[15:0];
            state_q <= S_WHOLE;
          end
        end
        S_WHOLE: begin
          whole_q <= whole_prod[31:19];
          state_q <= S_CLASS;
        end
        S_CLASS: begin
          pend_q.event_res    <= EvMeasure;
          pend_q.elapsed_ms   <= ms_q;
          pend_q.speed_tenths <= spd_q;
          priority if (whole_q > 13'(high_eff)) begin
            pend_q.limit_class <= ClassAbove;
          end else if (whole_q < 13'(low_q)) begin
            pend_q.limit_class <= ClassBelow;
          end else begin
            pend_q.limit_class <= ClassWithin;
          end
          pend_q.servo_pulse <= ServoTop - {1'b0, servo_prod[20:16]};
          state_q            <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            res_q       <= pend_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = out_valid_q;
  assign out_o.event_res    = res_q.event_res;
  assign out_o.elapsed_ms   = res_q.elapsed_ms;
  assign out_o.speed_tenths = res_q.speed_tenths;
  assign out_o.limit_class  = res_q.limit_class;
  assign out_o.servo_pulse  = res_q.servo_pulse;

  a_div_done_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV_MS || state_q == S_DIV_SPD))
    else $error("divider finished outside a divide state");

  a_disarmed_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> !armed_q)
    else $error("meter still armed while a result is pending");

  a_servo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.servo_pulse >= 6'd11 && res_q.servo_pulse <= ServoTop))
    else $error("servo value out of range");

  a_timeout_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.event_res == EvTimeout) |->
      (res_q.elapsed_ms == 16'd0 && res_q.servo_pulse == ServoTop))
    else $error("timeout result carries measurement fields");

  a_start_from_idle_ms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> (state_q == S_DIV_MS || state_q == S_DIV_SPD))
    else $error("divider started without a divide state following");

endmodule

// File: sv/lgsm_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
module lgsm_div
  import lgsm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivDenW:0]   rem_q, rem_d, rem_sh;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic               ge;

  assign rem_sh = {rem_q[DivDenW-1:0], quo_q[DivNumW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_d  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  assign quo_d  = {quo_q[DivNumW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivNumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the light gate speed meter with a built-in predictor.
module tb_top;
  import lgsm_pkg::*;

  localparam logic KindSample = 1'b0;
  localparam logic KindTick   = 1'b1;

  localparam int unsigned IdlePct     = 33;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned PhaseItems  = 80;
  localparam int unsigned MaxReports  = 10;

  localparam int unsigned TenthsScale = 1000;
  localparam int unsigned ServoZero   = 34;
  localparam int unsigned ServoSpan   = 23;
  localparam int unsigned WholeCap    = 99;
  localparam int unsigned CountMax    = 65535;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  lgsm_in_if  in_ch ();
  lgsm_out_if out_ch ();
  lgsm_cfg_if cfg_ch ();

  light_gate_speed_meter dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // Predictor copy of the registers and of the gate timing state.
  logic [6:0]  low_reg     = LowLimitRst;
  logic [6:0]  high_reg    = HighLimitRst;
  logic [7:0]  spacing_reg = GateDistanceRst;
  logic [7:0]  tpm_reg     = TicksPerMsRst;
  logic [15:0] tmo_reg     = TimeoutTicksRst;
  logic        start_lvl   = 1'b1;
  logic        stop_lvl    = 1'b1;
  logic        timing      = 1'b0;
  logic [15:0] tick_cnt    = '0;

  res_t        due_results[$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  logic        steady = 1'b0;
  logic        holding = 1'b0;
  event        hold_go;

  function automatic res_t speed_reading();
    int unsigned div, ms, spd, whole, capped, hi;
    res_t r;
    div = (tpm_reg == 0) ? 1 : tpm_reg;
    ms = tick_cnt / div;
    if (ms == 0) begin
      spd = CountMax;
    end else begin
      spd = (spacing_reg * TenthsScale) / ms;
      if (spd > CountMax) begin
        spd = CountMax;
      end
    end
    whole = spd / 10;
    hi = (high_reg < low_reg) ? low_reg : high_reg;
    capped = (whole > WholeCap) ? WholeCap : whole;
    r.event_res = EvMeasure;
    r.elapsed_ms = 16'(ms);
    r.speed_tenths = 16'(spd);
    if (whole > hi) begin
      r.limit_class = ClassAbove;
    end else if (whole < low_reg) begin
      r.limit_class = ClassBelow;
    end else begin
      r.limit_class = ClassWithin;
    end
    r.servo_pulse = 6'(ServoZero - (ServoSpan * capped) / WholeCap);
    return r;
  endfunction

  function automatic void meter_step(input logic kind, input logic start, input logic stop);
    res_t r;
    if (kind == KindTick) begin
      if (timing) begin
        if (tick_cnt != 16'(CountMax)) begin
          tick_cnt = tick_cnt + 16'd1;
        end
        if (tick_cnt >= tmo_reg) begin
          timing = 1'b0;
          r.event_res = EvTimeout;
          r.elapsed_ms = '0;
          r.speed_tenths = '0;
          r.limit_class = ClassWithin;
          r.servo_pulse = 6'(ServoZero);
          due_results.push_back(r);
        end
      end
    end else begin
      if (!start && start_lvl && !timing) begin
        timing = 1'b1;
        tick_cnt = '0;
      end
      if (!stop && stop_lvl && timing) begin
        timing = 1'b0;
        due_results.push_back(speed_reading());
      end
      start_lvl = start;
      stop_lvl = stop;
    end
  endfunction

  always @(posedge clk) begin
    out_ch.ready <= !holding && (steady || $urandom_range(99) >= IdlePct);
  end

  always begin
    @(hold_go);
    holding <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.event_res = out_ch.event_res;
      got.elapsed_ms = out_ch.elapsed_ms;
      got.speed_tenths = out_ch.speed_tenths;
      got.limit_class = out_ch.limit_class;
      got.servo_pulse = out_ch.servo_pulse;
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("Unexpected result: ev=%0d ms=%0d speed=%0d class=%0d servo=%0d",
                   got.event_res, got.elapsed_ms, got.speed_tenths, got.limit_class,
                   got.servo_pulse);
        end
      end else begin
        want = due_results.pop_front();
        if (got.event_res !== want.event_res || got.elapsed_ms !== want.elapsed_ms ||
            got.speed_tenths !== want.speed_tenths ||
            got.limit_class !== want.limit_class ||
            got.servo_pulse !== want.servo_pulse) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("Mismatch: expected ev=%0d ms=%0d speed=%0d class=%0d servo=%0d",
                     want.event_res, want.elapsed_ms, want.speed_tenths, want.limit_class,
                     want.servo_pulse);
            $display("          actual   ev=%0d ms=%0d speed=%0d class=%0d servo=%0d",
                     got.event_res, got.elapsed_ms, got.speed_tenths, got.limit_class,
                     got.servo_pulse);
          end
        end
      end
    end
  end

  task automatic send_item(input logic kind, input logic start, input logic stop);
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.start_clear <= start;
    in_ch.stop_clear <= stop;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    meter_step(kind, start, stop);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_settings(input logic [6:0] low, input logic [6:0] high,
                               input logic [7:0] spacing, input logic [7:0] tpm,
                               input logic [15:0] tmo);
    logic [CfgIdxW-1:0]  regs [5];
    logic [CfgDataW-1:0] vals [5];
    regs[0] = RegLowLimit;
    regs[1] = RegHighLimit;
    regs[2] = RegGateDistance;
    regs[3] = RegTicksPerMs;
    regs[4] = RegTimeoutTicks;
    vals[0] = 16'(low);
    vals[1] = 16'(high);
    vals[2] = 16'(spacing);
    vals[3] = 16'(tpm);
    vals[4] = tmo;
    settle();
    for (int i = 0; i < 5; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[i];
      cfg_ch.data <= vals[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    end
    cfg_ch.valid <= 1'b0;
    low_reg = low;
    high_reg = high;
    spacing_reg = spacing;
    tpm_reg = tpm;
    tmo_reg = tmo;
  endtask

  // A pass that is too fast to time in whole milliseconds saturates the speed.
  task automatic check_reset_settings();
    send_item(KindTick, 1'b1, 1'b1);
    send_item(KindSample, 1'b0, 1'b1);
    repeat (3) send_item(KindTick, 1'b0, 1'b1);
    send_item(KindSample, 1'b0, 1'b0);
    send_item(KindSample, 1'b1, 1'b1);
  endtask

  task automatic check_both_gates();
    send_item(KindSample, 1'b0, 1'b0);
    send_item(KindSample, 1'b1, 1'b1);
  endtask

  task automatic check_zero_settings();
    load_settings(7'd1, 7'd99, 8'd255, 8'd0, 16'd0);
    send_item(KindSample, 1'b0, 1'b1);
    send_item(KindTick, 1'b0, 1'b1);
    send_item(KindSample, 1'b1, 1'b0);
    send_item(KindSample, 1'b1, 1'b1);
    load_settings(7'd1, 7'd99, 8'd255, 8'd0, 16'd5);
    send_item(KindSample, 1'b0, 1'b1);
    send_item(KindTick, 1'b1, 1'b0);
    send_item(KindSample, 1'b1, 1'b0);
    send_item(KindSample, 1'b1, 1'b1);
  endtask

  task automatic check_inverted_limits();
    load_settings(7'd99, 7'd1, 8'd1, 8'd1, 16'hFFFF);
    send_item(KindSample, 1'b0, 1'b1);
    repeat (2) send_item(KindTick, 1'b1, 1'b1);
    send_item(KindSample, 1'b0, 1'b0);
    send_item(KindSample, 1'b1, 1'b1);
    load_settings(7'd40, 7'd10, 8'd200, 8'd1, 16'd100);
    send_item(KindSample, 1'b0, 1'b1);
    repeat (5) send_item(KindTick, 1'b1, 1'b1);
    send_item(KindSample, 1'b0, 1'b0);
  endtask

  task automatic check_output_stall();
    load_settings(LowLimitRst, HighLimitRst, GateDistanceRst, 8'd1, 16'd20);
    -> hold_go;
    for (int round = 0; round < 8; round++) begin
      send_item(KindSample, 1'b1, 1'b1);
      send_item(KindSample, 1'b0, 1'b1);
      repeat (round) send_item(KindTick, 1'b0, 1'b1);
      send_item(KindSample, 1'b1, 1'b0);
    end
  endtask

  task automatic random_pass();
    int unsigned n, top;
    if ($urandom_range(99) < 20) begin
      send_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end else begin
      top = (tmo_reg < 50) ? tmo_reg + 3 : 50;
      n = $urandom_range(top, 0);
      send_item(KindSample, 1'b1, 1'b1);
      send_item(KindSample, 1'b0, 1'b1);
      repeat (n) begin
        if ($urandom_range(99) < 10) begin
          send_item(KindSample, 1'($urandom_range(1)), 1'b1);
        end else begin
          send_item(KindTick, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      end
      send_item(KindSample, 1'($urandom_range(1)), 1'b0);
    end
  endtask

  task automatic check_random_traffic();
    logic [7:0]  tpm;
    logic [15:0] tmo;
    int unsigned target;
    for (int phase = 0; phase < 5; phase++) begin
      tpm = ($urandom_range(99) < 75) ? 8'($urandom_range(4, 1)) : 8'($urandom_range(255, 1));
      tmo = ($urandom_range(99) < 75) ? 16'($urandom_range(40, 1)) :
                                        16'($urandom_range(65535, 1));
      load_settings(7'($urandom_range(99, 1)), 7'($urandom_range(99, 1)),
                    8'($urandom_range(255, 1)), tpm, tmo);
      steady = (phase == 2);
      target = items_sent + PhaseItems;
      while (items_sent < target) random_pass();
      steady = 1'b0;
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KindSample;
    in_ch.start_clear = 1'b1;
    in_ch.stop_clear = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = RegLowLimit;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_reset_settings();
    check_both_gates();
    check_zero_settings();
    check_inverted_limits();
    check_output_stall();
    check_random_traffic();
    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: light_gate_speed_meter.f
sv/lgsm_pkg.sv
sv/lgsm_if.sv
sv/lgsm_div.sv
sv/light_gate_speed_meter.sv
sim/tb_top.sv
